>>> hw/rtl/bgl_pkg.sv
// Shared constants, types and register codes of the glyph line renderer.
`default_nettype none
package bgl_pkg;

    // Glyph memory size in bytes (a power of two) and its address width
    localparam int FONT_BYTES     = 262144;
    localparam int ADDR_W         = $clog2(FONT_BYTES);
    // Largest glyph side after clipping
    localparam int MAX_GLYPH_SIDE = 16;
    localparam int SIDE_W         = $clog2(MAX_GLYPH_SIDE + 1);
    // Bit accumulator: one full line plus one fetched byte
    localparam int ACC_W          = MAX_GLYPH_SIDE + 8;
    localparam int CNT_W          = $clog2(ACC_W + 1);
    // Pixels and bytes of one clipped glyph
    localparam int PIX_W          = $clog2(MAX_GLYPH_SIDE * MAX_GLYPH_SIDE + 1);
    localparam int BYTES_W        = $clog2((MAX_GLYPH_SIDE * MAX_GLYPH_SIDE + 7) / 8 + 1);
    // Offset wide enough to hold the row number of the row-mapped code
    localparam int OFF_W          = ADDR_W + 8;
    // Codes per row of the two-byte mapping
    localparam int ROW_CODES      = 94;

    // Fixed field widths
    localparam int CODE_W  = 16;
    localparam int COORD_W = 16;
    localparam int AVAIL_W = 15;
    localparam int MASK_W  = 16;
    localparam int GW_W    = 5;
    localparam int GB_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [SIDE_W-1:0]  side_t;
    typedef logic [OFF_W-1:0]   off_t;
    typedef logic [ACC_W-1:0]   acc_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [BYTES_W-1:0] nbytes_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_BYTES  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_MAPPED   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_BG      = 3'd7;

    // Register reset values
    localparam logic [CODE_W-1:0] FIRST_CODE_RST   = 16'hA1A1;
    localparam logic [CODE_W-1:0] LAST_CODE_RST    = 16'hF7FE;
    localparam logic [CODE_W-1:0] DEFAULT_CODE_RST = 16'hA3BF;
    localparam logic [GW_W-1:0]   GLYPH_WIDTH_RST  = 5'd16;
    localparam logic [GW_W-1:0]   GLYPH_HEIGHT_RST = 5'd16;
    localparam logic [GB_W-1:0]   GLYPH_BYTES_RST  = 6'd32;

    // Request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAP   = 5'b00010,
        ST_SCALE = 5'b00100,
        ST_BASE  = 5'b01000,
        ST_RUN   = 5'b10000
    } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/bgl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bgl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/bitmap_glyph_line_renderer.sv
// Top level of the glyph line renderer: request sequencer, address maths and line output.
//
// Channel   | Direction | Signals                                          | Transfer
// ----------+-----------+--------------------------------------------------+-------------------
// request   | in        | opcode, load_address, load_byte, char_code,      | start && !busy
//           |           | origin_x, origin_y, avail_width, avail_height    |
// line      | out       | line_x, line_y, fg_bits, bg_fill, line_width,    | line_valid
//           |           | advance, last_line                               |
// config    | in        | cfg_we, cfg_index, cfg_data                      | cfg_we
//
// A load writes the memory and leaves busy low. A draw keeps busy high through
// the address states (offset, row mapping, byte scaling) and then streams the
// glyph from the memory at one byte per cycle while the bit accumulator has
// room, emitting a line whenever enough bits are held. A glyph of zero height
// gives no line. Reset clears the sequencer and the configuration registers;
// the memory is not cleared. Each line is shown for one cycle and cannot be
// held off.
`default_nettype none
module bitmap_glyph_line_renderer (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Request
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                opcode,
    input  wire logic [17:0]                         load_address,
    input  wire logic [7:0]                          load_byte,
    input  wire logic [bgl_pkg::CODE_W-1:0]          char_code,
    input  wire logic signed [bgl_pkg::COORD_W-1:0]  origin_x,
    input  wire logic signed [bgl_pkg::COORD_W-1:0]  origin_y,
    input  wire logic [bgl_pkg::AVAIL_W-1:0]         avail_width,
    input  wire logic [bgl_pkg::AVAIL_W-1:0]         avail_height,
    // Lines
    output logic                                     line_valid,
    output logic signed [bgl_pkg::COORD_W-1:0]       line_x,
    output logic signed [bgl_pkg::COORD_W-1:0]       line_y,
    output logic [bgl_pkg::MASK_W-1:0]               fg_bits,
    output logic                                     bg_fill,
    output logic [4:0]                               line_width,
    output logic [4:0]                               advance,
    output logic                                     last_line,
    // Configuration
    input  wire logic                                cfg_we,
    input  wire logic [bgl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bgl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Configuration registers
    logic [bgl_pkg::CODE_W-1:0] first_code_reg;
    logic [bgl_pkg::CODE_W-1:0] last_code_reg;
    logic [bgl_pkg::CODE_W-1:0] default_code_reg;
    logic [bgl_pkg::GW_W-1:0]   glyph_width_reg;
    logic [bgl_pkg::GW_W-1:0]   glyph_height_reg;
    logic [bgl_pkg::GB_W-1:0]   glyph_bytes_reg;
    logic                       row_mapped_reg;
    logic                       draw_bg_reg;

    // Sequencer and draw context
    bgl_pkg::state_t            state_reg, state_next;
    logic [bgl_pkg::CODE_W-1:0] code_reg;
    logic signed [bgl_pkg::COORD_W-1:0] ox_reg;
    logic signed [bgl_pkg::COORD_W-1:0] oy_reg;
    bgl_pkg::side_t             w_reg;
    bgl_pkg::side_t             h_reg;
    bgl_pkg::off_t              off_reg;
    bgl_pkg::pix_t              pix_reg;
    bgl_pkg::addr_t             idx_reg;
    bgl_pkg::nbytes_t           nbytes_reg;
    bgl_pkg::addr_t             base_reg;
    bgl_pkg::nbytes_t           fetch_reg;
    bgl_pkg::side_t             line_reg;
    bgl_pkg::acc_t              acc_reg, acc_next;
    bgl_pkg::cnt_t              cnt_reg, cnt_next;
    logic                       pend_reg;

    // Memory ports
    logic                       mem_we;
    bgl_pkg::addr_t             mem_waddr;
    logic                       mem_re;
    bgl_pkg::addr_t             mem_raddr;
    logic [7:0]                 mem_rdata;

    logic                       accept;
    logic                       code_ok;
    logic [bgl_pkg::CODE_W-1:0] code_sel;
    bgl_pkg::side_t             w_clip;
    bgl_pkg::side_t             h_clip;
    logic                       emit;
    bgl_pkg::cnt_t              cnt_used;
    bgl_pkg::acc_t              acc_used;
    logic [bgl_pkg::MASK_W-1:0] mask;

    assign busy   = (state_reg != bgl_pkg::ST_IDLE);
    assign accept = start && !busy;

    // Load requests write the memory directly
    assign mem_we    = accept && (opcode == bgl_pkg::OP_LOAD);
    assign mem_waddr = bgl_pkg::addr_t'(load_address);

    bgl_ram #(
        .WIDTH(8),
        .DEPTH(bgl_pkg::FONT_BYTES)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (load_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Pick the code to draw and clip the glyph to the available area
    always_comb
    begin
        code_ok  = (char_code >= first_code_reg) && (char_code <= last_code_reg);
        code_sel = code_ok ? char_code : default_code_reg;
        w_clip   = bgl_pkg::side_t'(bgl_pkg::MAX_GLYPH_SIDE);
        if (32'(glyph_width_reg) < 32'(w_clip))
        begin
            w_clip = bgl_pkg::side_t'(glyph_width_reg);
        end
        if (32'(avail_width) < 32'(w_clip))
        begin
            w_clip = bgl_pkg::side_t'(avail_width);
        end
        h_clip = bgl_pkg::side_t'(bgl_pkg::MAX_GLYPH_SIDE);
        if (32'(glyph_height_reg) < 32'(h_clip))
        begin
            h_clip = bgl_pkg::side_t'(glyph_height_reg);
        end
        if (32'(avail_height) < 32'(h_clip))
        begin
            h_clip = bgl_pkg::side_t'(avail_height);
        end
    end

    // Stream bits: consume one line when held, append the byte that arrives
    always_comb
    begin
        emit     = (state_reg == bgl_pkg::ST_RUN) && (line_reg != h_reg)
                   && (cnt_reg >= bgl_pkg::cnt_t'(w_reg));
        cnt_used = emit ? cnt_reg - bgl_pkg::cnt_t'(w_reg) : cnt_reg;
        acc_used = emit ? acc_reg << w_reg : acc_reg;
        acc_next = acc_used;
        cnt_next = cnt_used;
        if (pend_reg)
        begin
            acc_next = acc_used
                       | (bgl_pkg::acc_t'({mem_rdata, {(bgl_pkg::ACC_W-8){1'b0}}}) >> cnt_used);
            cnt_next = cnt_used + bgl_pkg::cnt_t'(8);
        end
        mem_re    = (state_reg == bgl_pkg::ST_RUN) && (fetch_reg != nbytes_reg)
                    && (cnt_next <= bgl_pkg::cnt_t'(bgl_pkg::ACC_W - 8));
        mem_raddr = base_reg + bgl_pkg::addr_t'(fetch_reg);
    end

    // Mask of the line, leftmost pixel first
    always_comb
    begin
        for (int i = 0; i < bgl_pkg::MASK_W; i++)
        begin
            mask[i] = (i < bgl_pkg::ACC_W) && (32'(i) < 32'(w_reg))
                      && acc_reg[bgl_pkg::ACC_W - 1 - i];
        end
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bgl_pkg::ST_IDLE:
            begin
                if (accept && (opcode == bgl_pkg::OP_DRAW))
                begin
                    state_next = bgl_pkg::ST_MAP;
                end
            end
            bgl_pkg::ST_MAP:
            begin
                state_next = bgl_pkg::ST_SCALE;
            end
            bgl_pkg::ST_SCALE:
            begin
                state_next = bgl_pkg::ST_BASE;
            end
            bgl_pkg::ST_BASE:
            begin
                state_next = (h_reg == '0) ? bgl_pkg::ST_IDLE : bgl_pkg::ST_RUN;
            end
            bgl_pkg::ST_RUN:
            begin
                if (emit && (line_reg == h_reg - bgl_pkg::side_t'(1)))
                begin
                    state_next = bgl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bgl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bgl_pkg::ST_IDLE;
            line_valid       <= 1'b0;
            pend_reg         <= 1'b0;
            first_code_reg   <= bgl_pkg::FIRST_CODE_RST;
            last_code_reg    <= bgl_pkg::LAST_CODE_RST;
            default_code_reg <= bgl_pkg::DEFAULT_CODE_RST;
            glyph_width_reg  <= bgl_pkg::GLYPH_WIDTH_RST;
            glyph_height_reg <= bgl_pkg::GLYPH_HEIGHT_RST;
            glyph_bytes_reg  <= bgl_pkg::GLYPH_BYTES_RST;
            row_mapped_reg   <= 1'b1;
            draw_bg_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            line_valid <= emit;
            pend_reg   <= mem_re;
            // Take configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bgl_pkg::REG_FIRST_CODE:   first_code_reg   <= cfg_data;
                    bgl_pkg::REG_LAST_CODE:    last_code_reg    <= cfg_data;
                    bgl_pkg::REG_DEFAULT_CODE: default_code_reg <= cfg_data;
                    bgl_pkg::REG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[bgl_pkg::GW_W-1:0];
                    bgl_pkg::REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[bgl_pkg::GW_W-1:0];
                    bgl_pkg::REG_GLYPH_BYTES:  glyph_bytes_reg  <= cfg_data[bgl_pkg::GB_W-1:0];
                    bgl_pkg::REG_ROW_MAPPED:   row_mapped_reg   <= cfg_data[0];
                    bgl_pkg::REG_DRAW_BG:      draw_bg_reg      <= cfg_data[0];
                    default:                   ;
                endcase
            end
        end
    end

    // Draw context, address maths and bit stream
    always_ff @(posedge clk)
    begin
        // Hold the request
        if (accept && (opcode == bgl_pkg::OP_DRAW))
        begin
            code_reg <= code_sel;
            ox_reg   <= origin_x;
            oy_reg   <= origin_y;
            w_reg    <= w_clip;
            h_reg    <= h_clip;
        end
        // Offset from the first code, wrapping
        if (state_reg == bgl_pkg::ST_MAP)
        begin
            off_reg <= bgl_pkg::off_t'(code_reg) - bgl_pkg::off_t'(first_code_reg);
            pix_reg <= bgl_pkg::pix_t'(w_reg) * bgl_pkg::pix_t'(h_reg);
        end
        // Row mapping: 94 codes per row
        if (state_reg == bgl_pkg::ST_SCALE)
        begin
            if (row_mapped_reg)
            begin
                idx_reg <= bgl_pkg::addr_t'(off_reg[bgl_pkg::OFF_W-1:8]
                                            * bgl_pkg::addr_t'(bgl_pkg::ROW_CODES))
                           + bgl_pkg::addr_t'(off_reg[7:0]);
            end
            else
            begin
                idx_reg <= off_reg[bgl_pkg::ADDR_W-1:0];
            end
            nbytes_reg <= bgl_pkg::nbytes_t'((pix_reg + bgl_pkg::pix_t'(7)) >> 3);
        end
        // Scale by bytes per glyph and clear the stream
        if (state_reg == bgl_pkg::ST_BASE)
        begin
            base_reg  <= bgl_pkg::addr_t'(idx_reg * bgl_pkg::addr_t'(glyph_bytes_reg));
            fetch_reg <= '0;
            line_reg  <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end
        if (state_reg == bgl_pkg::ST_RUN)
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            if (mem_re)
            begin
                fetch_reg <= fetch_reg + bgl_pkg::nbytes_t'(1);
            end
            if (emit)
            begin
                line_reg <= line_reg + bgl_pkg::side_t'(1);
            end
        end
        // Present a line
        if (emit)
        begin
            line_x     <= ox_reg;
            line_y     <= oy_reg + bgl_pkg::COORD_W'(line_reg);
            fg_bits    <= mask;
            bg_fill    <= draw_bg_reg;
            line_width <= 5'(w_reg);
            advance    <= 5'(w_reg);
            last_line  <= (line_reg == h_reg - bgl_pkg::side_t'(1));
        end
    end

`ifndef ASSERT_OFF
    // The final line ends the draw; earlier lines leave it running
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && last_line |-> !busy)
        else $error("final line shown while still busy");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && !last_line |-> busy)
        else $error("line shown after draw ended");

    // A pending memory read always lands during streaming
    a_pend_run: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == bgl_pkg::ST_RUN))
        else $error("glyph byte arrived outside streaming");

    // The accumulator never overflows
    a_cnt_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bgl_pkg::ST_RUN) |-> (cnt_reg <= bgl_pkg::cnt_t'(bgl_pkg::ACC_W)))
        else $error("bit accumulator overflow");
`endif

endmodule
`default_nettype wire

>>> sim/bitmap_glyph_line_renderer_test.sv
// Self-checking testbench of the glyph line renderer: directed table, then random traffic.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_glyph_line_renderer_test;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    // Settling wait, with margin over the slowest draw
    localparam int SETTLE_CYCLES = 48;
    localparam int QUIET_LIMIT   = 4000;
    localparam int ITEM_TARGET   = 410;
    localparam int SEG_BUDGET    = 45;
    localparam int PRINT_CAP     = 40;

    typedef enum {ROW_CFG, ROW_LOAD, ROW_DRAW} row_kind_t;

    typedef struct {
        logic                               op;
        logic [bgl_pkg::ADDR_W-1:0]         addr;
        logic [7:0]                         data;
        logic [bgl_pkg::CODE_W-1:0]         code;
        logic signed [bgl_pkg::COORD_W-1:0] ox;
        logic signed [bgl_pkg::COORD_W-1:0] oy;
        logic [bgl_pkg::AVAIL_W-1:0]        aw;
        logic [bgl_pkg::AVAIL_W-1:0]        ah;
    } request_t;

    typedef struct packed {
        logic signed [bgl_pkg::COORD_W-1:0] x;
        logic signed [bgl_pkg::COORD_W-1:0] y;
        logic [bgl_pkg::MASK_W-1:0]         fg;
        logic                               bg;
        logic [4:0]                         width;
        logic [4:0]                         adv;
        logic                               last;
    } line_t;

    // n_lines of -1 leaves the row to the glyph predictor
    typedef struct {
        row_kind_t kind;
        int        target;
        int        data;
        int        code;
        int        ox;
        int        oy;
        int        aw;
        int        ah;
        int        n_lines;
        int        fg;
        int        w;
    } plan_row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic                               opcode;
    logic [17:0]                        load_address;
    logic [7:0]                         load_byte;
    logic [bgl_pkg::CODE_W-1:0]         char_code;
    logic signed [bgl_pkg::COORD_W-1:0] origin_x;
    logic signed [bgl_pkg::COORD_W-1:0] origin_y;
    logic [bgl_pkg::AVAIL_W-1:0]        avail_width;
    logic [bgl_pkg::AVAIL_W-1:0]        avail_height;
    logic                               line_valid;
    logic signed [bgl_pkg::COORD_W-1:0] line_x;
    logic signed [bgl_pkg::COORD_W-1:0] line_y;
    logic [bgl_pkg::MASK_W-1:0]         fg_bits;
    logic                               bg_fill;
    logic [4:0]                         line_width;
    logic [4:0]                         advance;
    logic                               last_line;
    logic                               cfg_we;
    logic [bgl_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [bgl_pkg::CFG_DATA_W-1:0]     cfg_data;

    // Register copies kept in step with the writes
    logic [bgl_pkg::CODE_W-1:0] font_lo;
    logic [bgl_pkg::CODE_W-1:0] font_hi;
    logic [bgl_pkg::CODE_W-1:0] fallback_code;
    logic [bgl_pkg::GW_W-1:0]   glyph_w;
    logic [bgl_pkg::GW_W-1:0]   glyph_h;
    logic [bgl_pkg::GB_W-1:0]   glyph_stride;
    logic                       row_mode;
    logic                       bg_mode;

    // Glyph memory copy and the set of bytes loaded so far
    logic [7:0] font_mem [0:bgl_pkg::FONT_BYTES-1];
    bit         font_seen [0:bgl_pkg::FONT_BYTES-1];

    line_t     pending_lines [$];
    line_t     want_line;
    plan_row_t plan [$];
    int        mismatch_count;
    int        quiet_cycles;
    int        items_sent;
    bit        settled;

    bitmap_glyph_line_renderer dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Clipped side: smallest of the available span, the register and the side limit
    function automatic int clip_side(logic [bgl_pkg::AVAIL_W-1:0] avail,
                                     logic [bgl_pkg::GW_W-1:0] limit);
        int s;
        s = avail;
        if (limit < s)
            s = limit;
        if (bgl_pkg::MAX_GLYPH_SIDE < s)
            s = bgl_pkg::MAX_GLYPH_SIDE;
        return s;
    endfunction

    // Base byte of a glyph, after the fallback and the optional row mapping
    function automatic logic [bgl_pkg::ADDR_W-1:0] glyph_address(
        logic [bgl_pkg::CODE_W-1:0] code);
        logic [bgl_pkg::CODE_W-1:0] pick;
        logic [31:0]                off;
        pick = (code < font_lo || code > font_hi) ? fallback_code : code;
        off = {16'd0, pick} - {16'd0, font_lo};
        if (row_mode)
            off = 32'(bgl_pkg::ROW_CODES) * (off >> 8) + (off & 32'h0000_00FF);
        off = off * {26'd0, glyph_stride};
        return off[bgl_pkg::ADDR_W-1:0];
    endfunction

    function automatic int glyph_byte_count(logic [bgl_pkg::AVAIL_W-1:0] aw,
                                            logic [bgl_pkg::AVAIL_W-1:0] ah);
        int n;
        n = clip_side(aw, glyph_w) * clip_side(ah, glyph_h);
        return (n + 7) / 8;
    endfunction

    function automatic void queue_line(logic signed [bgl_pkg::COORD_W-1:0] x,
                                       logic signed [bgl_pkg::COORD_W-1:0] y,
                                       logic [bgl_pkg::MASK_W-1:0] fg,
                                       logic [4:0] width, bit last);
        line_t ln;
        ln = '{x, y, fg, bg_mode, width, width, last};
        pending_lines.push_back(ln);
    endfunction

    // Predict every line of a draw from the packed MSB-first glyph stream
    function automatic void render_glyph_lines(request_t r);
        int                         w;
        int                         h;
        int                         pos;
        logic [bgl_pkg::MASK_W-1:0] mask;
        logic [bgl_pkg::ADDR_W-1:0] base;
        logic [bgl_pkg::ADDR_W-1:0] byte_at;
        w = clip_side(r.aw, glyph_w);
        h = clip_side(r.ah, glyph_h);
        base = glyph_address(r.code);
        for (int row = 0; row < h; row++)
        begin
            mask = '0;
            for (int b = 0; b < w; b++)
            begin
                pos = row * w + b;
                byte_at = base + bgl_pkg::ADDR_W'(pos >> 3);
                if (font_mem[byte_at][7 - (pos % 8)])
                    mask[b] = 1'b1;
            end
            queue_line(r.ox, r.oy + 16'(row), mask, 5'(w), row == h - 1);
        end
    endfunction

    function automatic request_t make_load(int addr, int data);
        request_t r;
        r.op   = bgl_pkg::OP_LOAD;
        r.addr = bgl_pkg::ADDR_W'(addr);
        r.data = 8'(data);
        r.code = '0;
        r.ox   = '0;
        r.oy   = '0;
        r.aw   = '0;
        r.ah   = '0;
        return r;
    endfunction

    function automatic request_t make_draw(int code, int ox, int oy, int aw, int ah);
        request_t r;
        r.op   = bgl_pkg::OP_DRAW;
        r.addr = bgl_pkg::ADDR_W'($urandom);
        r.data = 8'($urandom);
        r.code = bgl_pkg::CODE_W'(code);
        r.ox   = bgl_pkg::COORD_W'(ox);
        r.oy   = bgl_pkg::COORD_W'(oy);
        r.aw   = bgl_pkg::AVAIL_W'(aw);
        r.ah   = bgl_pkg::AVAIL_W'(ah);
        return r;
    endfunction

    function automatic plan_row_t plan_row(row_kind_t kind, int target, int data,
                                           int code = 0, int ox = 0, int oy = 0,
                                           int aw = 0, int ah = 0, int n_lines = -1,
                                           int fg = 0, int w = 0);
        plan_row_t p;
        p = '{kind, target, data, code, ox, oy, aw, ah, n_lines, fg, w};
        return p;
    endfunction

    // Mostly small spans, some saturated, some anywhere in the field
    function automatic int pick_avail();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(0, 18);
        if (r < 85)
            return 32'h7FFF;
        return $urandom_range(0, 32'h7FFF);
    endfunction

    // Junk above the register width; the block keeps the low bits only
    function automatic logic [bgl_pkg::CFG_DATA_W-1:0] pad_reg(int value, int width);
        logic [bgl_pkg::CFG_DATA_W-1:0] junk;
        junk = bgl_pkg::CFG_DATA_W'($urandom) << width;
        return junk | bgl_pkg::CFG_DATA_W'(value);
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    // Present one request, hold it until the transfer, then predict its lines
    task automatic send_request(request_t r, int typed_lines = -1, int typed_fg = 0,
                                int typed_w = 0);
        int idle_pct;
        idle_pct = (items_sent < ITEM_TARGET / 3) ? 18 :
                   (items_sent < 2 * ITEM_TARGET / 3) ? 61 : 0;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        opcode       <= r.op;
        load_address <= r.addr;
        load_byte    <= r.data;
        char_code    <= r.code;
        origin_x     <= r.ox;
        origin_y     <= r.oy;
        avail_width  <= r.aw;
        avail_height <= r.ah;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        settled = 1'b0;
        if (r.op == bgl_pkg::OP_LOAD)
        begin
            font_mem[r.addr]  = r.data;
            font_seen[r.addr] = 1'b1;
        end
        else if (typed_lines >= 0)
        begin
            for (int i = 0; i < typed_lines; i++)
                queue_line(r.ox, r.oy + 16'(i), bgl_pkg::MASK_W'(typed_fg), 5'(typed_w),
                           i == typed_lines - 1);
        end
        else
            render_glyph_lines(r);
    endtask

    // Load every byte a draw will read that has not been loaded yet
    task automatic fill_glyph(request_t d);
        logic [bgl_pkg::ADDR_W-1:0] base;
        int                         n;
        base = glyph_address(d.code);
        n = glyph_byte_count(d.aw, d.ah);
        for (int i = 0; i < n; i++)
        begin
            if (!font_seen[base + bgl_pkg::ADDR_W'(i)])
                send_request(make_load(base + bgl_pkg::ADDR_W'(i), $urandom));
        end
    endtask

    task automatic stop_requests();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Wait for every line owed, then let a draw with no lines finish
    task automatic drain_and_settle();
        stop_requests();
        while (pending_lines.size() != 0)
            @(posedge clk);
        if (!settled)
            repeat (SETTLE_CYCLES) @(posedge clk);
        settled = 1'b1;
    endtask

    task automatic write_reg(logic [bgl_pkg::CFG_IDX_W-1:0] idx,
                             logic [bgl_pkg::CFG_DATA_W-1:0] value);
        drain_and_settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            bgl_pkg::REG_FIRST_CODE:   font_lo       = value;
            bgl_pkg::REG_LAST_CODE:    font_hi       = value;
            bgl_pkg::REG_DEFAULT_CODE: fallback_code = value;
            bgl_pkg::REG_GLYPH_WIDTH:  glyph_w       = value[bgl_pkg::GW_W-1:0];
            bgl_pkg::REG_GLYPH_HEIGHT: glyph_h       = value[bgl_pkg::GW_W-1:0];
            bgl_pkg::REG_GLYPH_BYTES:  glyph_stride  = value[bgl_pkg::GB_W-1:0];
            bgl_pkg::REG_ROW_MAPPED:   row_mode      = value[0];
            bgl_pkg::REG_DRAW_BG:      bg_mode       = value[0];
            default:                   ;
        endcase
    endtask

    // Program all registers for one random segment; the first few are fixed extremes
    task automatic program_profile(int seg);
        int lo;
        int hi;
        int fb;
        int gw;
        int gh;
        int gb;
        int rm;
        int bg;
        fb = $urandom_range(0, 16'hFFFF);
        case (seg)
            0:
            begin
                lo = bgl_pkg::FIRST_CODE_RST; hi = bgl_pkg::LAST_CODE_RST;
                fb = bgl_pkg::DEFAULT_CODE_RST;
                gw = 16; gh = 16; gb = 32; rm = 1; bg = 0;
            end
            1:
            begin
                lo = 0; hi = 16'hFFFF; gw = 31; gh = 31; gb = 63; rm = 0; bg = 1;
            end
            2:
            begin
                lo = 16'hFFFF; hi = 0; gw = 0; gh = 0; gb = 0; rm = 1; bg = 1;
            end
            3:
            begin
                lo = 16'hFFFF; hi = 0; gw = 1; gh = 1; gb = 1; rm = 0; bg = 0;
            end
            default:
            begin
                lo = $urandom_range(0, 16'hFFFF);
                hi = ($urandom_range(3) == 0) ? $urandom_range(0, 16'hFFFF)
                                              : lo + $urandom_range(0, 2000);
                if (hi > 16'hFFFF)
                    hi = 16'hFFFF;
                gw = ($urandom_range(4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
                gh = ($urandom_range(4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
                gb = ($urandom_range(4) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
                rm = $urandom_range(1);
                bg = $urandom_range(1);
            end
        endcase
        write_reg(bgl_pkg::REG_FIRST_CODE, bgl_pkg::CFG_DATA_W'(lo));
        write_reg(bgl_pkg::REG_LAST_CODE, bgl_pkg::CFG_DATA_W'(hi));
        write_reg(bgl_pkg::REG_DEFAULT_CODE, bgl_pkg::CFG_DATA_W'(fb));
        write_reg(bgl_pkg::REG_GLYPH_WIDTH, pad_reg(gw, bgl_pkg::GW_W));
        write_reg(bgl_pkg::REG_GLYPH_HEIGHT, pad_reg(gh, bgl_pkg::GW_W));
        write_reg(bgl_pkg::REG_GLYPH_BYTES, pad_reg(gb, bgl_pkg::GB_W));
        write_reg(bgl_pkg::REG_ROW_MAPPED, pad_reg(rm, 1));
        write_reg(bgl_pkg::REG_DRAW_BG, pad_reg(bg, 1));
    endtask

    // Check each line against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && line_valid)
        begin
            if (pending_lines.size() == 0)
                flag_mismatch("line with none owed, fg_bits", fg_bits, 0);
            else
            begin
                want_line = pending_lines.pop_front();
                if (line_x !== want_line.x)
                    flag_mismatch("line_x", line_x, want_line.x);
                if (line_y !== want_line.y)
                    flag_mismatch("line_y", line_y, want_line.y);
                if (fg_bits !== want_line.fg)
                    flag_mismatch("fg_bits", fg_bits, want_line.fg);
                if (bg_fill !== want_line.bg)
                    flag_mismatch("bg_fill", bg_fill, want_line.bg);
                if (line_width !== want_line.width)
                    flag_mismatch("line_width", line_width, want_line.width);
                if (advance !== want_line.adv)
                    flag_mismatch("advance", advance, want_line.adv);
                if (last_line !== want_line.last)
                    flag_mismatch("last_line", last_line, want_line.last);
            end
        end
    end

    // Stop the run when no transfer has happened for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || line_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [bgl_pkg::CODE_W-1:0] pool [4];
        int                         pool_n;
        int                         span;
        int                         seg;
        int                         seg_start;
        int                         budget;
        int                         pick;
        request_t                   d;

        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = bgl_pkg::OP_LOAD;
        load_address = '0;
        load_byte    = '0;
        char_code    = '0;
        origin_x     = '0;
        origin_y     = '0;
        avail_width  = '0;
        avail_height = '0;
        cfg_we       = 1'b0;
        cfg_index    = bgl_pkg::REG_FIRST_CODE;
        cfg_data     = '0;
        font_lo       = bgl_pkg::FIRST_CODE_RST;
        font_hi       = bgl_pkg::LAST_CODE_RST;
        fallback_code = bgl_pkg::DEFAULT_CODE_RST;
        glyph_w       = bgl_pkg::GLYPH_WIDTH_RST;
        glyph_h       = bgl_pkg::GLYPH_HEIGHT_RST;
        glyph_stride  = bgl_pkg::GLYPH_BYTES_RST;
        row_mode      = 1'b1;
        bg_mode       = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        settled        = 1'b0;

        // Directed rows: reset values first, then a small linear font
        plan.push_back(plan_row(ROW_DRAW, 0, 0, 16'hA1A1, 0, 0, 100, 0, 0));
        plan.push_back(plan_row(ROW_DRAW, 0, 0, 16'h0000, -32768, 32767, 0, 32767,
                                16, 0, 0));
        plan.push_back(plan_row(ROW_CFG, bgl_pkg::REG_FIRST_CODE, 16'h0010));
        plan.push_back(plan_row(ROW_CFG, bgl_pkg::REG_LAST_CODE, 16'h0020));
        plan.push_back(plan_row(ROW_CFG, bgl_pkg::REG_DEFAULT_CODE, 16'h0008));
        plan.push_back(plan_row(ROW_CFG, bgl_pkg::REG_GLYPH_WIDTH, 8));
        plan.push_back(plan_row(ROW_CFG, bgl_pkg::REG_GLYPH_HEIGHT, 2));
        plan.push_back(plan_row(ROW_CFG, bgl_pkg::REG_GLYPH_BYTES, 2));
        plan.push_back(plan_row(ROW_CFG, bgl_pkg::REG_ROW_MAPPED, 0));
        plan.push_back(plan_row(ROW_CFG, bgl_pkg::REG_DRAW_BG, 1));
        plan.push_back(plan_row(ROW_LOAD, 0, 8'hFF));
        plan.push_back(plan_row(ROW_LOAD, 1, 8'hFF));
        plan.push_back(plan_row(ROW_DRAW, 0, 0, 16'h0010, 32767, -32768, 32767, 32767,
                                2, 16'h00FF, 8));
        plan.push_back(plan_row(ROW_LOAD, 2, 8'h00));
        plan.push_back(plan_row(ROW_LOAD, 3, 8'h00));
        plan.push_back(plan_row(ROW_DRAW, 0, 0, 16'h0011, 5, 7, 8, 2, 2, 16'h0000, 8));
        // Bit order across bytes
        plan.push_back(plan_row(ROW_LOAD, 4, 8'h80));
        plan.push_back(plan_row(ROW_LOAD, 5, 8'h01));
        plan.push_back(plan_row(ROW_DRAW, 0, 0, 16'h0012, 100, 200, 16, 16));
        // Codes below and above the range fall back; the fallback lies below first
        plan.push_back(plan_row(ROW_DRAW, 0, 0, 16'h0005, -1, -1, 16, 16));
        plan.push_back(plan_row(ROW_DRAW, 0, 0, 16'hFFFF, 3, 4, 9, 1));
        plan.push_back(plan_row(ROW_DRAW, 0, 0, 16'h0020, 0, 0, 5, 1));
        // Top memory byte, then a narrow glyph packed across lines
        plan.push_back(plan_row(ROW_LOAD, 18'h3FFFF, 8'hA5));
        plan.push_back(plan_row(ROW_DRAW, 0, 0, 16'h0010, 9, 9, 3, 16));
        // Base at the top of memory: the stream wraps to address zero
        plan.push_back(plan_row(ROW_CFG, bgl_pkg::REG_GLYPH_BYTES, 1));
        plan.push_back(plan_row(ROW_CFG, bgl_pkg::REG_DEFAULT_CODE, 16'h000F));
        plan.push_back(plan_row(ROW_DRAW, 0, 0, 16'h000F, 1, 2, 16, 16));
        plan.push_back(plan_row(ROW_CFG, bgl_pkg::REG_ROW_MAPPED, 1));
        plan.push_back(plan_row(ROW_DRAW, 0, 0, 16'h0110, -5, 12, 16, 16));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_CFG:
                    write_reg(bgl_pkg::CFG_IDX_W'(plan[i].target),
                              bgl_pkg::CFG_DATA_W'(plan[i].data));
                ROW_LOAD:
                    send_request(make_load(plan[i].target, plan[i].data));
                default:
                begin
                    d = make_draw(plan[i].code, plan[i].ox, plan[i].oy, plan[i].aw, plan[i].ah);
                    fill_glyph(d);
                    send_request(d, plan[i].n_lines, plan[i].fg, plan[i].w);
                end
            endcase
        end

        // Random segments, each under its own register setting
        seg = 0;
        while (items_sent < ITEM_TARGET)
        begin
            program_profile(seg);
            budget = (seg == 2) ? 10 : SEG_BUDGET;
            // Few codes per segment so that each glyph is loaded once and drawn often
            pool_n = (glyph_w >= 16 && glyph_h >= 16) ? 2 : 4;
            span = int'(font_hi) - int'(font_lo);
            for (int k = 0; k < pool_n; k++)
            begin
                if (k == pool_n - 1 || span < 0)
                    pool[k] = bgl_pkg::CODE_W'($urandom);
                else
                    pool[k] = font_lo + bgl_pkg::CODE_W'(($urandom_range(0, 3) * 256
                                                + $urandom_range(0, 93)) % (span + 1));
            end
            seg_start = items_sent;
            while (items_sent - seg_start < budget && items_sent < ITEM_TARGET)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    d = make_draw(pool[$urandom_range(0, pool_n - 1)], $urandom, $urandom,
                                  pick_avail(), pick_avail());
                    fill_glyph(d);
                    send_request(d);
                end
                else if (pick < 66)
                begin
                    // Any code, kept short so that its fill stays small
                    d = make_draw($urandom, $urandom, $urandom, pick_avail(),
                                  $urandom_range(0, 2));
                    fill_glyph(d);
                    send_request(d);
                end
                else if (pick < 88)
                    send_request(make_load(glyph_address(pool[$urandom_range(0, pool_n - 1)])
                                           + bgl_pkg::ADDR_W'($urandom_range(0, 31)),
                                           $urandom));
                else
                    send_request(make_load($urandom, $urandom));
            end
            seg++;
        end

        // Drain, let the block go quiet, then give the verdict
        stop_requests();
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_lines.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

>>> bitmap_glyph_line_renderer.f
hw/rtl/bgl_pkg.sv
hw/rtl/bgl_ram.sv
hw/rtl/bitmap_glyph_line_renderer.sv
sim/bitmap_glyph_line_renderer_test.sv
